// ===== rtl/fpt_pkg.sv =====
// package for the four-level page table manager
// types, constants and entry helpers; no dependencies
package fpt_pkg;

  localparam int unsigned TableFrames  = 64;
  localparam int unsigned EntriesPerTbl = 512;
  localparam int unsigned IdentityDirs = 4;
  localparam int unsigned FrameW       = $clog2(TableFrames);
  localparam int unsigned IdxW         = 9;
  localparam int unsigned AddrW        = FrameW + IdxW;
  localparam int unsigned Depth        = TableFrames * EntriesPerTbl;
  localparam int unsigned FreeW        = FrameW + 1;

  localparam logic [51:0] TableBaseRst = 52'h100000;
  localparam logic [63:0] FlagP = 64'h1;
  localparam logic [63:0] FlagW = 64'h2;
  localparam logic [63:0] FlagH = 64'h80;
  localparam logic [63:0] FlagG = 64'h100;
  localparam logic [63:0] AddrMask = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] HugeMask = 64'h000F_FFFF_FFE0_0000;

  typedef enum logic [1:0] {
    ActMap   = 2'd0,
    ActUnmap = 2'd1,
    ActXlate = 2'd2,
    ActNone  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoFrame  = 2'd1,
    StConflict = 2'd2,
    StNotMap   = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [47:0] virt_addr;
    logic [51:0] phys_addr;
    logic [11:0] page_flags;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [51:0] phys_out;
    logic        tlb_flush;
  } rsp_t;

  // entry contents of the identity map built at reset
  function automatic logic [63:0] reset_entry(logic [AddrW-1:0] a, logic [51:0] base);
    logic [FrameW-1:0] f;
    logic [IdxW-1:0]   j;
    logic [63:0]       r;
    f = a[AddrW-1:IdxW];
    j = a[IdxW-1:0];
    r = '0;
    if (f == FrameW'(0) && j == '0) begin
      r = ((64'(base) + 64'd4096) & AddrMask) | FlagP | FlagW | FlagG;
    end else if (f == FrameW'(1) && 32'(j) < IdentityDirs) begin
      r = ((64'(base) + 64'(32'(j) + 2) * 64'd4096) & AddrMask) | FlagP | FlagW | FlagG;
    end else if (32'(f) >= 2 && 32'(f) < 2 + IdentityDirs) begin
      r = (((64'(f) - 64'd2) << 30) | (64'(j) << 21)) | FlagP | FlagW | FlagH | FlagG;
    end
    return r;
  endfunction

endpackage

// ===== rtl/fpt_ram.sv =====
// generic single-port synchronous ram with registered read
// no dependencies
module fpt_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== rtl/four_level_page_table_manager_unit.sv =====
// top level of the four-level page table manager
// depends on fpt_pkg and fpt_ram
//
// usage: drive req_i and pulse start_i while busy_o is low; the request is a
// map, unmap or translate of one 48-bit virtual address, or a no-op. exactly one result
// appears on rsp_o for one cycle with done_o high; it cannot be held off.
// table_base is written through cfg_we_i / cfg_wdata_i while idle.
// the table store is one memory of 32768 entries of 64 bits, one access a
// cycle, with a registered read. a translate or unmap walks up to four levels,
// each level a read, then a check. a map that needs new tables clears all 512
// entries of each one, then links it into its parent. every entry read or
// write holds the state machine.
// after reset the block runs a clearing pass over all 32768 entries that writes
// the identity map of the low 4 GiB (busy_o high), then accepts requests.
// the memory has no reset; entries in frames above the identity map are
// written zero by the pass or when a table is allocated.
module four_level_page_table_manager_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  fpt_pkg::req_t req_i,
  output logic          done_o,
  output fpt_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic [51:0]   cfg_wdata_i
);
  import fpt_pkg::*;

  typedef enum logic [7:0] {
    SInit  = 8'b0000_0001,
    SIdle  = 8'b0000_0010,
    SRead  = 8'b0000_0100,
    SCheck = 8'b0000_1000,
    SClear = 8'b0001_0000,
    SLink  = 8'b0010_0000,
    SLeaf  = 8'b0100_0000,
    SDone  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [51:0] base_q;
  logic [AddrW-1:0] init_q, init_d;
  logic [FreeW-1:0] free_q, free_d;
  req_t req_q, req_d;
  logic [1:0] lvl_q, lvl_d;          // 3 pml4, 2 pdpt, 1 pd, 0 pt
  logic [FrameW-1:0] frm_q, frm_d;
  logic [FrameW-1:0] nf_q, nf_d;
  logic [IdxW-1:0] clr_q, clr_d;
  rsp_t rsp_q, rsp_d;

  logic ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [63:0] ram_wdata, ram_rdata;

  fpt_ram #(.Width(64), .Depth(Depth)) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  logic [IdxW-1:0] idx;
  logic [51:0] off;
  logic [39:0] foff;
  logic in_store;
  logic [FrameW-1:0] child;
  logic [63:0] link_entry;

  always_comb begin
    unique case (lvl_q)
      2'd3:    idx = req_q.virt_addr[47:39];
      2'd2:    idx = req_q.virt_addr[38:30];
      2'd1:    idx = req_q.virt_addr[29:21];
      default: idx = req_q.virt_addr[20:12];
    endcase
    off = (ram_rdata[51:0] & AddrMask[51:0]) - base_q;
    foff = off[51:12];
    in_store = (foff < 40'(TableFrames));
    child = foff[FrameW-1:0];
    link_entry = ((64'(base_q) + 64'(nf_q) * 64'd4096) & AddrMask) | FlagP | FlagW | FlagG;
  end

  always_comb begin
    state_d = state_q;
    init_d = init_q;
    free_d = free_q;
    req_d = req_q;
    lvl_d = lvl_q;
    frm_d = frm_q;
    nf_d = nf_q;
    clr_d = clr_q;
    rsp_d = rsp_q;
    ram_we = 1'b0;
    ram_addr = {frm_q, idx};
    ram_wdata = '0;
    unique case (state_q)
      SInit: begin
        ram_we = 1'b1;
        ram_addr = init_q;
        ram_wdata = reset_entry(init_q, TableBaseRst);
        init_d = init_q + AddrW'(1);
        if (init_q == AddrW'(Depth - 1)) state_d = SIdle;
      end
      SIdle: begin
        if (start_i) begin
          req_d = req_i;
          lvl_d = 2'd3;
          frm_d = '0;
          rsp_d = '0;
          if (action_e'(req_i.action) == ActNone) state_d = SDone;
          else state_d = SRead;
        end
      end
      SRead: state_d = SCheck;
      SCheck: begin
        if (action_e'(req_q.action) == ActMap) begin
          if (lvl_q == 2'd0) begin
            state_d = SLeaf;
          end else if (lvl_q == 2'd1 && ram_rdata[0] && ram_rdata[7]) begin
            rsp_d.status = StConflict;
            state_d = SDone;
          end else if (ram_rdata[0]) begin
            if (in_store) begin
              frm_d = child;
              lvl_d = lvl_q - 2'd1;
              state_d = SRead;
            end else begin
              rsp_d.status = StNoFrame;
              state_d = SDone;
            end
          end else if (free_q >= FreeW'(TableFrames)) begin
            rsp_d.status = StNoFrame;
            state_d = SDone;
          end else begin
            nf_d = free_q[FrameW-1:0];
            free_d = free_q + FreeW'(1);
            clr_d = '0;
            state_d = SClear;
          end
        end else begin
          if (!ram_rdata[0]) begin
            if (lvl_q == 2'd0 && action_e'(req_q.action) == ActUnmap) begin
              state_d = SLeaf;
            end else begin
              rsp_d.status = StNotMap;
              state_d = SDone;
            end
          end else if (lvl_q == 2'd1 && ram_rdata[7]) begin
            if (action_e'(req_q.action) == ActXlate) begin
              rsp_d.phys_out = (ram_rdata[51:0] & HugeMask[51:0])
                             | {31'd0, req_q.virt_addr[20:0]};
            end else begin
              rsp_d.status = StNotMap;
            end
            state_d = SDone;
          end else if (lvl_q == 2'd0) begin
            if (action_e'(req_q.action) == ActUnmap) begin
              state_d = SLeaf;
            end else begin
              rsp_d.phys_out = (ram_rdata[51:0] & AddrMask[51:0])
                             | {40'd0, req_q.virt_addr[11:0]};
              state_d = SDone;
            end
          end else if (in_store) begin
            frm_d = child;
            lvl_d = lvl_q - 2'd1;
            state_d = SRead;
          end else begin
            rsp_d.status = StNotMap;
            state_d = SDone;
          end
        end
      end
      SClear: begin
        ram_we = 1'b1;
        ram_addr = {nf_q, clr_q};
        clr_d = clr_q + IdxW'(1);
        if (clr_q == IdxW'(EntriesPerTbl - 1)) state_d = SLink;
      end
      SLink: begin
        ram_we = 1'b1;
        ram_wdata = link_entry;
        frm_d = nf_q;
        lvl_d = lvl_q - 2'd1;
        state_d = SRead;
      end
      SLeaf: begin
        ram_we = 1'b1;
        if (action_e'(req_q.action) == ActMap) begin
          ram_wdata = ({12'd0, req_q.phys_addr} & AddrMask)
                    | {52'd0, req_q.page_flags} | FlagP;
        end
        rsp_d.tlb_flush = 1'b1;
        state_d = SDone;
      end
      SDone: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SInit;
      init_q <= '0;
      free_q <= FreeW'(2 + IdentityDirs);
      base_q <= TableBaseRst;
    end else begin
      state_q <= state_d;
      init_q <= init_d;
      free_q <= free_d;
      if (cfg_we_i) base_q <= cfg_wdata_i & AddrMask[51:0];
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    lvl_q <= lvl_d;
    frm_q <= frm_d;
    nf_q <= nf_d;
    clr_q <= clr_d;
    rsp_q <= rsp_d;
  end

  assign busy_o = (state_q != SIdle);
  assign done_o = (state_q == SDone);
  assign rsp_o  = rsp_q;

  a_flush_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.tlb_flush |-> rsp_o.status == StOk)
    else $error("flush with error status");
  a_phys_xlate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.phys_out != '0 |-> action_e'(req_q.action) == ActXlate)
    else $error("address returned for non-translate");
  a_free_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= FreeW'(TableFrames))
    else $error("allocator overrun");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held");
endmodule

// ===== dv/tb_four_level_page_table_manager_unit.sv =====
// testbench for the four-level page table manager: directed table, then random
// map / unmap / translate traffic over several table_base settings, checked
// against an in-bench page walk predictor; depends on fpt_pkg and the rtl
`timescale 1ns / 100ps

module tb_four_level_page_table_manager_unit;
  import fpt_pkg::*;

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t e;
  } vec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  req_t        req_i = '0;
  logic        done_o;
  rsp_t        rsp_o;
  logic        cfg_we_i = 1'b0;
  logic [51:0] cfg_wdata_i = '0;

  logic [63:0] pt_mem [TableFrames*EntriesPerTbl];
  logic [51:0] base_q;
  int          next_frame;
  rsp_t        xlate_q [$];
  int          errors = 0;
  int          cycles = 0;
  int          burst_left = 0;
  logic [47:21] region [8];
  vec_t        dir [$];

  four_level_page_table_manager_unit u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .done_o, .rsp_o, .cfg_we_i, .cfg_wdata_i
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int frame_of_entry(logic [63:0] e);
    logic [51:0] off;
    off = e[51:0] & AddrMask[51:0];
    off = off - (base_q & AddrMask[51:0]);
    if ((off >> 12) >= TableFrames) return -1;
    return int'(off >> 12);
  endfunction

  function automatic int walk_or_alloc(int frame, logic [8:0] idx);
    logic [63:0] e;
    int nf;
    e = pt_mem[frame*512 + idx];
    if (e[0]) return frame_of_entry(e);
    if (next_frame >= TableFrames) return -1;
    nf = next_frame;
    next_frame++;
    for (int k = 0; k < 512; k++) pt_mem[nf*512 + k] = '0;
    pt_mem[frame*512 + idx] = ((64'(base_q) + 64'(nf) * 64'd4096) & AddrMask)
                              | FlagP | FlagW | FlagG;
    return nf;
  endfunction

  function automatic int walk(int frame, logic [8:0] idx);
    logic [63:0] e;
    e = pt_mem[frame*512 + idx];
    if (!e[0]) return -1;
    return frame_of_entry(e);
  endfunction

  function automatic rsp_t predict_walk(req_t r);
    rsp_t o;
    logic [8:0] i4, i3, i2, i1;
    logic [63:0] pde, pte;
    int pdpt, pd, pt;
    o = '0;
    i4 = r.virt_addr[47:39];
    i3 = r.virt_addr[38:30];
    i2 = r.virt_addr[29:21];
    i1 = r.virt_addr[20:12];
    if (r.action == ActMap) begin
      pdpt = walk_or_alloc(0, i4);
      pd = (pdpt < 0) ? -1 : walk_or_alloc(pdpt, i3);
      if (pd < 0) begin
        o.status = StNoFrame;
      end else begin
        pde = pt_mem[pd*512 + i2];
        if (pde[0] && pde[7]) begin
          o.status = StConflict;
        end else begin
          pt = walk_or_alloc(pd, i2);
          if (pt < 0) begin
            o.status = StNoFrame;
          end else begin
            pt_mem[pt*512 + i1] = ({12'h0, r.phys_addr} & AddrMask) | 64'(r.page_flags) | FlagP;
            o.tlb_flush = 1'b1;
          end
        end
      end
    end else if (r.action == ActUnmap || r.action == ActXlate) begin
      o.status = StNotMap;
      pdpt = walk(0, i4);
      pd = (pdpt < 0) ? -1 : walk(pdpt, i3);
      if (pd >= 0) begin
        pde = pt_mem[pd*512 + i2];
        if (pde[0]) begin
          if (pde[7]) begin
            if (r.action == ActXlate) begin
              o.status = StOk;
              o.phys_out = pde[51:0] & HugeMask[51:0] | 52'(r.virt_addr[20:0]);
            end
          end else begin
            pt = frame_of_entry(pde);
            if (pt >= 0) begin
              if (r.action == ActUnmap) begin
                pt_mem[pt*512 + i1] = '0;
                o.status = StOk;
                o.tlb_flush = 1'b1;
              end else begin
                pte = pt_mem[pt*512 + i1];
                if (pte[0]) begin
                  o.status = StOk;
                  o.phys_out = pte[51:0] & AddrMask[51:0] | 52'(r.virt_addr[11:0]);
                end
              end
            end
          end
        end
      end
    end
    return o;
  endfunction

  // one transaction, with bursts and random gaps on the sender side
  task automatic send_req(req_t r, bit typed, rsp_t e);
    bit ok;
    rsp_t p;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    start_i <= 1'b1;
    req_i   <= r;
    forever begin
      @(negedge clk_i);
      ok = !busy_o;
      @(posedge clk_i);
      if (ok) break;
    end
    p = predict_walk(r);
    xlate_q.push_back(typed ? e : p);
    burst_left--;
  endtask

  task automatic write_base(logic [51:0] v);
    start_i <= 1'b0;
    burst_left = 0;
    while (xlate_q.size() != 0) @(posedge clk_i);
    forever begin
      @(negedge clk_i);
      if (!busy_o) break;
    end
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    base_q = v & AddrMask[51:0];
  endtask

  function automatic req_t rand_req();
    req_t r;
    int sel;
    r.phys_addr  = 52'({$urandom(), $urandom()});
    r.page_flags = 12'($urandom());
    sel = $urandom_range(0, 99);
    if (sel < 4) begin
      r.action = 2'($urandom_range(0, 3));
      r.virt_addr = 48'({$urandom(), $urandom()});
    end else begin
      r.virt_addr = {region[$urandom_range(0, 7)], 9'($urandom_range(0, 15)), 12'($urandom())};
      sel = $urandom_range(0, 99);
      r.action = (sel < 40) ? ActMap : (sel < 80) ? ActXlate : (sel < 96) ? ActUnmap : ActNone;
    end
    return r;
  endfunction

  function automatic vec_t row(action_e a, logic [47:0] va, logic [51:0] pa, logic [11:0] fl,
                               bit typed, status_e st, logic [51:0] po, logic fo);
    vec_t v;
    v.r = '{action: a, virt_addr: va, phys_addr: pa, page_flags: fl};
    v.typed = typed;
    v.e = '{status: st, phys_out: po, tlb_flush: fo};
    return v;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni && done_o) begin
      if (xlate_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual %h", $time, rsp_o);
      end else begin
        rsp_t e;
        e = xlate_q.pop_front();
        if (rsp_o.status !== e.status) begin
          errors++;
          $display("%0t status: expected %0d actual %0d", $time, e.status, rsp_o.status);
        end
        if (rsp_o.phys_out !== e.phys_out) begin
          errors++;
          $display("%0t phys_out: expected %h actual %h", $time, e.phys_out, rsp_o.phys_out);
        end
        if (rsp_o.tlb_flush !== e.tlb_flush) begin
          errors++;
          $display("%0t tlb_flush: expected %b actual %b", $time, e.tlb_flush, rsp_o.tlb_flush);
        end
      end
    end
  end

  initial begin
    logic [51:0] bases [5];
    int counts [5];
    rsp_t none;
    none = '0;
    for (int k = 0; k < TableFrames*EntriesPerTbl; k++) pt_mem[k] = '0;
    base_q = TableBaseRst;
    next_frame = 2 + IdentityDirs;
    pt_mem[0] = ((64'(base_q) + 64'd4096) & AddrMask) | FlagP | FlagW | FlagG;
    for (int i = 0; i < IdentityDirs; i++) begin
      pt_mem[512 + i] = ((64'(base_q) + 64'(i + 2) * 64'd4096) & AddrMask)
                        | FlagP | FlagW | FlagG;
      for (int j = 0; j < 512; j++)
        pt_mem[(2 + i)*512 + j] = (64'(i) << 30) | (64'(j) << 21)
                                  | FlagP | FlagW | FlagH | FlagG;
    end
    region[0] = {9'h0, 9'($urandom_range(0, 3)), 9'($urandom())};
    for (int k = 1; k < 8; k++) region[k] = {9'($urandom_range(1, 3)), 18'($urandom())};

    dir.push_back(row(ActXlate, 48'h0, 52'h0, 12'h0, 1'b1, StOk, 52'h0, 1'b0));
    dir.push_back(row(ActXlate, 48'hFFFF_FFFF, 52'h0, 12'h0, 1'b1, StOk, 52'hFFFF_FFFF, 1'b0));
    dir.push_back(row(ActXlate, 48'h1_0000_0000, 52'h0, 12'h0, 1'b1, StNotMap, 52'h0, 1'b0));
    dir.push_back(row(ActUnmap, 48'h1000, 52'h0, 12'h0, 1'b1, StNotMap, 52'h0, 1'b0));
    dir.push_back(row(ActMap, 48'h1000, 52'h5000, 12'h3, 1'b1, StConflict, 52'h0, 1'b0));
    dir.push_back(row(ActNone, 48'hFFFF_FFFF_FFFF, '1, '1, 1'b1, StOk, 52'h0, 1'b0));
    dir.push_back(row(ActMap, 48'hFFFF_FFFF_FFFF, '1, '1, 1'b1, StOk, 52'h0, 1'b1));
    dir.push_back(row(ActXlate, 48'hFFFF_FFFF_FFFF, '0, '0, 1'b1, StOk, '1, 1'b0));
    dir.push_back(row(ActUnmap, 48'hFFFF_FFFF_FFFF, '0, '0, 1'b1, StOk, 52'h0, 1'b1));
    dir.push_back(row(ActXlate, 48'hFFFF_FFFF_FFFF, '0, '0, 1'b1, StNotMap, 52'h0, 1'b0));
    dir.push_back(row(ActUnmap, 48'hFFFF_FFFF_F000, '0, '0, 1'b1, StOk, 52'h0, 1'b1));
    dir.push_back(row(ActUnmap, 48'h8000_0000_0000, '0, '0, 1'b1, StNotMap, 52'h0, 1'b0));
    // present forced on a leaf mapped with no flags
    dir.push_back(row(ActMap, 48'hFFFF_FFFF_E000, 52'h0, 12'h0, 1'b0, StOk, 52'h0, 1'b0));
    dir.push_back(row(ActXlate, 48'hFFFF_FFFF_EABC, 52'h0, 12'h0, 1'b0, StOk, 52'h0, 1'b0));
    dir.push_back(row(ActMap, 48'h0000_4000_0000, 52'h0, 12'h0, 1'b0, StOk, 52'h0, 1'b0));
    dir.push_back(row(ActXlate, 48'h0000_4000_0000, 52'h0, 12'h0, 1'b0, StOk, 52'h0, 1'b0));
    dir.push_back(row(ActMap, 48'h0080_0000_1000, 52'hA_BCDE_F012_3456, 12'hAAA, 1'b0, StOk,
                      52'h0, 1'b0));
    dir.push_back(row(ActXlate, 48'h0080_0000_1555, 52'h0, 12'h0, 1'b0, StOk, 52'h0, 1'b0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir[k]) send_req(dir[k].r, dir[k].typed, dir[k].e);

    bases  = '{TableBaseRst, 52'h0, '1, TableBaseRst - 52'h3000, TableBaseRst | 52'hABC};
    counts = '{620, 60, 60, 60, 240};
    for (int ph = 0; ph < 5; ph++) begin
      write_base(bases[ph]);
      repeat (counts[ph]) send_req(rand_req(), 1'b0, none);
    end

    start_i <= 1'b0;
    while (xlate_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
